FILE: hdl/rsi_pkg.sv
// Shared constants, register indexes and pipeline types for the ray/sphere intersection block.
`default_nettype none

package rsi_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int LANES      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(3);

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

    localparam int LIMB_W  = 24;
    localparam int LIMBS   = 3;
    localparam int MUL_W   = LIMB_W * LIMBS;
    localparam int ROW_W   = LIMB_W * (LIMBS + 1);
    localparam int PROD_W  = 2 * MUL_W;
    localparam int MUL_LAT = 3;

    localparam int T_W         = COORD_W + 1;
    localparam int DT_W        = 2 * COORD_W + 1;
    localparam int TT_W        = 2 * COORD_W + 1;
    localparam int RR_W        = 2 * RAD_W;
    localparam int A_W         = 2 * COORD_W;
    localparam int B_W         = 67;
    localparam int K_W         = 68;
    localparam int BMAG_W      = 66;
    localparam int KMAG_W      = 66;
    localparam int DISC_FULL_W = 134;
    localparam int DISC_W      = 126;
    localparam int SQ_REM_W    = DISC_W + 1;
    localparam int ROOT_W      = 63;
    localparam int DIFF_W      = 67;
    localparam int QMAG_W      = 66;
    localparam int NMAG_W      = 97;
    localparam int NUM_W       = 99;
    localparam int DEN_W       = A_W + 1;
    localparam int QUO_W       = 33;
    localparam int DREM_W      = NUM_W - QUO_W;
    localparam int PSUM_W      = 35;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    typedef struct packed {
        logic [LANES-1:0][COORD_W-1:0] org;
        logic [LANES-1:0][COORD_W-1:0] dmag;
        logic [LANES-1:0]              dneg;
        logic [A_W-1:0]                a;
        logic [BMAG_W-1:0]             bmag;
        logic                          bpos;
        logic                          miss;
    } rsi_side_t;

endpackage

`default_nettype wire

FILE: hdl/rsi_if.sv
// Handshake channel interfaces for rays, results and configuration writes.
`default_nettype none

interface rsi_ray_if;
    import rsi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsi_res_if;
    import rsi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    modport source (output valid, hit, point_x, point_y, point_z, input ready);
    modport sink (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

interface rsi_cfg_if;
    import rsi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ray_sphere_intersect.sv
// Throughput: one ray per cycle; a new ray is taken every cycle the pipeline can advance.
// The 63-stage square root and the 33-stage divider, one bit per stage, set the depth.
// A stalled result holds the pipeline only once its last stage is also occupied.
// Reset clears all valid bits and loads center 0 and radius 1.0; no clearing pass is needed.
`default_nettype none

module ray_sphere_intersect (
    input  logic      clk,
    input  logic      rst_n,
    rsi_ray_if.sink   ray,
    rsi_res_if.source result,
    rsi_cfg_if.sink   cfg
);
    import rsi_pkg::*;

    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] cz_reg;
    logic [RAD_W-1:0]          rad_reg;

    logic en;
    logic out_load;

    logic                      s0_vld_reg;
    logic signed [COORD_W-1:0] s0_o_reg [LANES];
    logic signed [COORD_W-1:0] s0_d_reg [LANES];
    logic signed [T_W-1:0]     s0_t_reg [LANES];

    logic                  s1_vld_reg;
    logic [A_W-1:0]        s1_dd_reg [LANES];
    logic signed [DT_W-1:0] s1_dt_reg [LANES];
    logic [TT_W-1:0]       s1_tt_reg [LANES];
    logic [RR_W-1:0]       s1_rr_reg;
    rsi_side_t             s1_side_reg;

    logic                  s2_vld_reg;
    logic [A_W-1:0]        s2_a_reg;
    logic signed [B_W-1:0] s2_b_reg;
    logic signed [K_W-1:0] s2_k_reg;
    rsi_side_t             s2_side_reg;

    logic              s3_vld_reg;
    rsi_side_t         s3_side_reg;
    rsi_side_t         s3_side_next;
    logic [KMAG_W-1:0] s3_kmag_reg;
    logic [KMAG_W-1:0] s3_kmag_next;
    logic              s3_kneg_reg;

    logic [PROD_W-1:0] bb_prod;
    logic [PROD_W-1:0] ak_prod;
    logic              m1_vld_reg  [MUL_LAT];
    rsi_side_t         m1_side_reg [MUL_LAT];
    logic              m1_kneg_reg [MUL_LAT];

    logic [DISC_FULL_W-1:0] disc_next;
    logic                   s4_vld_reg;
    rsi_side_t              s4_side_reg;
    rsi_side_t              s4_side_next;
    logic [DISC_W-1:0]      s4_rad_reg;

    logic              sq_vld;
    rsi_side_t         sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic                     s5_vld_reg;
    rsi_side_t                s5_side_reg;
    logic signed [DIFF_W-1:0] s5_diff_reg;

    logic              s6_vld_reg;
    rsi_side_t         s6_side_reg;
    logic [QMAG_W-1:0] s6_qmag_reg;
    logic              s6_qneg_reg;

    logic [PROD_W-1:0] n_prod [LANES];
    logic              m2_vld_reg  [MUL_LAT];
    rsi_side_t         m2_side_reg [MUL_LAT];
    logic              m2_qneg_reg [MUL_LAT];

    logic             s7_vld_reg;
    rsi_side_t        s7_side_reg;
    logic [NUM_W-1:0] s7_num_reg [LANES];
    logic [LANES-1:0] s7_nneg_reg;

    logic                         s8_vld_reg;
    rsi_side_t                    s8_side_reg;
    logic [LANES-1:0][DREM_W-1:0] s8_rem_reg;
    logic [LANES-1:0][QUO_W-1:0]  s8_low_reg;
    logic [LANES-1:0]             s8_big_reg;
    logic [LANES-1:0]             s8_nneg_reg;

    logic                         dv_vld_reg  [QUO_W];
    rsi_side_t                    dv_side_reg [QUO_W];
    logic [LANES-1:0][DREM_W-1:0] dv_rem_reg  [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  dv_low_reg  [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]  dv_q_reg    [QUO_W];
    logic [LANES-1:0]             dv_big_reg  [QUO_W];
    logic [LANES-1:0]             dv_nneg_reg [QUO_W];

    logic                     f1_vld_reg;
    logic                     f1_miss_reg;
    logic [LANES-1:0]         f1_big_reg;
    logic [LANES-1:0]         f1_nneg_reg;
    logic signed [PSUM_W-1:0] f1_p_reg [LANES];

    logic                      f2_vld_reg;
    logic                      f2_hit_reg;
    logic signed [COORD_W-1:0] f2_pt_reg  [LANES];
    logic signed [COORD_W-1:0] f2_pt_next [LANES];

    logic                      res_vld_reg;
    logic                      res_hit_reg;
    logic signed [COORD_W-1:0] res_pt_reg [LANES];

    // Flow control: the pipeline moves unless its last stage holds an item
    // that the output register cannot take.
    assign out_load  = !res_vld_reg || result.ready;
    assign en        = !f2_vld_reg || out_load;
    assign ray.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= RADIUS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_CENTER_X: cx_reg  <= $signed(cfg.data);
                REG_CENTER_Y: cy_reg  <= $signed(cfg.data);
                REG_CENTER_Z: cz_reg  <= $signed(cfg.data);
                REG_RADIUS:   rad_reg <= cfg.data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            for (int i = 0; i < MUL_LAT; i++)
            begin
                m1_vld_reg[i] <= 1'b0;
                m2_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_vld_reg    <= ray.valid;
            s1_vld_reg    <= s0_vld_reg;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            m1_vld_reg[0] <= s3_vld_reg;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                m1_vld_reg[i] <= m1_vld_reg[i-1];
                m2_vld_reg[i] <= m2_vld_reg[i-1];
            end
            s4_vld_reg    <= m1_vld_reg[MUL_LAT-1];
            s5_vld_reg    <= sq_vld;
            s6_vld_reg    <= s5_vld_reg;
            m2_vld_reg[0] <= s6_vld_reg;
            s7_vld_reg    <= m2_vld_reg[MUL_LAT-1];
            s8_vld_reg    <= s7_vld_reg;
            f1_vld_reg    <= dv_vld_reg[QUO_W-1];
            f2_vld_reg    <= f1_vld_reg;
        end
    end

    // Stages 0 to 2: offset from the center, the three dot products and R squared.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_o_reg[0] <= ray.origin_x;
            s0_o_reg[1] <= ray.origin_y;
            s0_o_reg[2] <= ray.origin_z;
            s0_d_reg[0] <= ray.dir_x;
            s0_d_reg[1] <= ray.dir_y;
            s0_d_reg[2] <= ray.dir_z;
            s0_t_reg[0] <= T_W'(ray.origin_x) - T_W'(cx_reg);
            s0_t_reg[1] <= T_W'(ray.origin_y) - T_W'(cy_reg);
            s0_t_reg[2] <= T_W'(ray.origin_z) - T_W'(cz_reg);

            for (int i = 0; i < LANES; i++)
            begin
                s1_dd_reg[i] <= A_W'(A_W'(s0_d_reg[i]) * A_W'(s0_d_reg[i]));
                s1_dt_reg[i] <= DT_W'(s0_d_reg[i]) * DT_W'(s0_t_reg[i]);
                s1_tt_reg[i] <= TT_W'((TT_W+1)'(s0_t_reg[i]) * (TT_W+1)'(s0_t_reg[i]));
                s1_side_reg.org[i]  <= s0_o_reg[i];
                s1_side_reg.dneg[i] <= s0_d_reg[i][COORD_W-1];
                s1_side_reg.dmag[i] <= s0_d_reg[i][COORD_W-1] ? $unsigned(-s0_d_reg[i])
                                                               : $unsigned(s0_d_reg[i]);
            end
            s1_side_reg.a    <= '0;
            s1_side_reg.bmag <= '0;
            s1_side_reg.bpos <= 1'b0;
            s1_side_reg.miss <= 1'b0;
            s1_rr_reg        <= RR_W'(rad_reg) * RR_W'(rad_reg);

            s2_a_reg    <= s1_dd_reg[0] + s1_dd_reg[1] + s1_dd_reg[2];
            s2_b_reg    <= B_W'(s1_dt_reg[0]) + B_W'(s1_dt_reg[1]) + B_W'(s1_dt_reg[2]);
            s2_k_reg    <= $signed(K_W'(s1_tt_reg[0]) + K_W'(s1_tt_reg[1])
                                   + K_W'(s1_tt_reg[2]) - K_W'(s1_rr_reg));
            s2_side_reg <= s1_side_reg;
        end
    end

    // Stage 3: magnitudes and signs of B and K for the unsigned multipliers.
    always_comb
    begin
        s3_side_next      = s2_side_reg;
        s3_side_next.a    = s2_a_reg;
        s3_side_next.bmag = BMAG_W'(s2_b_reg[B_W-1] ? -s2_b_reg : s2_b_reg);
        s3_side_next.bpos = !s2_b_reg[B_W-1] && (s2_b_reg != '0);
        s3_side_next.miss = (s2_a_reg == '0);
        s3_kmag_next      = KMAG_W'(s2_k_reg[K_W-1] ? -s2_k_reg : s2_k_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s3_side_next;
            s3_kmag_reg <= s3_kmag_next;
            s3_kneg_reg <= s2_k_reg[K_W-1];
        end
    end

    rsi_mul u_mul_bb (
        .clk (clk),
        .en  (en),
        .a   (MUL_W'(s3_side_reg.bmag)),
        .b   (MUL_W'(s3_side_reg.bmag)),
        .p   (bb_prod)
    );

    rsi_mul u_mul_ak (
        .clk (clk),
        .en  (en),
        .a   (MUL_W'(s3_side_reg.a)),
        .b   (MUL_W'(s3_kmag_reg)),
        .p   (ak_prod)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg[0] <= s3_side_reg;
            m1_kneg_reg[0] <= s3_kneg_reg;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                m1_side_reg[i] <= m1_side_reg[i-1];
                m1_kneg_reg[i] <= m1_kneg_reg[i-1];
            end
        end
    end

    // Stage 4: discriminant B*B - A*K; a negative value is a miss.
    always_comb
    begin
        disc_next = m1_kneg_reg[MUL_LAT-1]
                  ? DISC_FULL_W'(bb_prod) + DISC_FULL_W'(ak_prod)
                  : DISC_FULL_W'(bb_prod) - DISC_FULL_W'(ak_prod);
        s4_side_next      = m1_side_reg[MUL_LAT-1];
        s4_side_next.miss = m1_side_reg[MUL_LAT-1].miss || disc_next[DISC_FULL_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
            s4_rad_reg  <= disc_next[DISC_W-1:0];
        end
    end

    rsi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_side  (s4_side_reg),
        .in_rad   (s4_rad_reg),
        .out_vld  (sq_vld),
        .out_side (sq_side),
        .out_root (sq_root)
    );

    // Stages 5 and 6: numerator of the nearer root, as sign and magnitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= sq_side;
            s5_diff_reg <= $signed(DIFF_W'(sq_side.bmag) - DIFF_W'(sq_root));

            s6_side_reg <= s5_side_reg;
            s6_qmag_reg <= QMAG_W'(s5_diff_reg[DIFF_W-1] ? -s5_diff_reg : s5_diff_reg);
            s6_qneg_reg <= s5_side_reg.bpos
                         ? (!s5_diff_reg[DIFF_W-1] && (s5_diff_reg != '0))
                         : s5_diff_reg[DIFF_W-1];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_nmul
        rsi_mul u_mul_n (
            .clk (clk),
            .en  (en),
            .a   (MUL_W'(s6_side_reg.dmag[l])),
            .b   (MUL_W'(s6_qmag_reg)),
            .p   (n_prod[l])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_side_reg[0] <= s6_side_reg;
            m2_qneg_reg[0] <= s6_qneg_reg;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                m2_side_reg[i] <= m2_side_reg[i-1];
                m2_qneg_reg[i] <= m2_qneg_reg[i-1];
            end
        end
    end

    // Stages 7 and 8: rounded quotient setup (2|n| + A) / 2A and the overflow check.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_side_reg <= m2_side_reg[MUL_LAT-1];
            for (int i = 0; i < LANES; i++)
            begin
                s7_num_reg[i]  <= NUM_W'({n_prod[i][NMAG_W-1:0], 1'b0})
                                + NUM_W'(m2_side_reg[MUL_LAT-1].a);
                s7_nneg_reg[i] <= m2_side_reg[MUL_LAT-1].dneg[i] ^ m2_qneg_reg[MUL_LAT-1];
            end

            s8_side_reg <= s7_side_reg;
            s8_nneg_reg <= s7_nneg_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s8_rem_reg[i] <= s7_num_reg[i][NUM_W-1:QUO_W];
                s8_low_reg[i] <= s7_num_reg[i][QUO_W-1:0];
                s8_big_reg[i] <= s7_num_reg[i][NUM_W-1:QUO_W]
                               >= DREM_W'({s7_side_reg.a, 1'b0});
            end
        end
    end

    // Restoring divider, one quotient bit per stage, three lanes side by side.
    for (genvar s = 0; s < QUO_W; s++)
    begin : g_div
        logic                         vld_in;
        rsi_side_t                    side_in;
        logic [LANES-1:0][DREM_W-1:0] rem_in;
        logic [LANES-1:0][QUO_W-1:0]  low_in;
        logic [LANES-1:0][QUO_W-1:0]  q_in;
        logic [LANES-1:0]             big_in;
        logic [LANES-1:0]             nneg_in;
        logic [LANES-1:0][DREM_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0]  q_next;

        if (s == 0)
        begin : g_first
            assign vld_in  = s8_vld_reg;
            assign side_in = s8_side_reg;
            assign rem_in  = s8_rem_reg;
            assign low_in  = s8_low_reg;
            assign q_in    = '0;
            assign big_in  = s8_big_reg;
            assign nneg_in = s8_nneg_reg;
        end
        else
        begin : g_rest
            assign vld_in  = dv_vld_reg[s-1];
            assign side_in = dv_side_reg[s-1];
            assign rem_in  = dv_rem_reg[s-1];
            assign low_in  = dv_low_reg[s-1];
            assign q_in    = dv_q_reg[s-1];
            assign big_in  = dv_big_reg[s-1];
            assign nneg_in = dv_nneg_reg[s-1];
        end

        always_comb
        begin
            logic [DREM_W:0] r2;
            logic [DREM_W:0] den;
            logic            ge;
            den = (DREM_W+1)'({side_in.a, 1'b0});
            for (int l = 0; l < LANES; l++)
            begin
                r2          = {rem_in[l], low_in[l][QUO_W-1-s]};
                ge          = r2 >= den;
                rem_next[l] = DREM_W'(ge ? r2 - den : r2);
                q_next[l]   = q_in[l] | (QUO_W'(ge) << (QUO_W - 1 - s));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[s] <= side_in;
                dv_rem_reg[s]  <= rem_next;
                dv_low_reg[s]  <= low_in;
                dv_q_reg[s]    <= q_next;
                dv_big_reg[s]  <= big_in;
                dv_nneg_reg[s] <= nneg_in;
            end
        end
    end

    // Final stages: add the signed offset to the origin, then saturate.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_miss_reg <= dv_side_reg[QUO_W-1].miss;
            f1_big_reg  <= dv_big_reg[QUO_W-1];
            f1_nneg_reg <= dv_nneg_reg[QUO_W-1];
            for (int i = 0; i < LANES; i++)
            begin
                f1_p_reg[i] <= $signed(PSUM_W'($signed(dv_side_reg[QUO_W-1].org[i]))
                             + (dv_nneg_reg[QUO_W-1][i] ? -PSUM_W'(dv_q_reg[QUO_W-1][i])
                                                        : PSUM_W'(dv_q_reg[QUO_W-1][i])));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            priority if (f1_miss_reg)
                f2_pt_next[i] = '0;
            else if (f1_big_reg[i])
                f2_pt_next[i] = f1_nneg_reg[i] ? COORD_MIN : COORD_MAX;
            else if (f1_p_reg[i] > PSUM_W'(COORD_MAX))
                f2_pt_next[i] = COORD_MAX;
            else if (f1_p_reg[i] < PSUM_W'(COORD_MIN))
                f2_pt_next[i] = COORD_MIN;
            else
                f2_pt_next[i] = f1_p_reg[i][COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_hit_reg <= !f1_miss_reg;
            f2_pt_reg  <= f2_pt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_hit_reg <= f2_hit_reg;
            res_pt_reg  <= f2_pt_reg;
        end
    end

    assign result.valid   = res_vld_reg;
    assign result.hit     = res_hit_reg;
    assign result.point_x = res_pt_reg[0];
    assign result.point_y = res_pt_reg[1];
    assign result.point_z = res_pt_reg[2];

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |->
            result.point_x == '0 && result.point_y == '0 && result.point_z == '0)
        else $error("miss result carries a nonzero point");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        f2_vld_reg && result.valid && !result.ready |-> !ray.ready)
        else $error("input accepted while the full pipeline is stalled");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(f2_vld_reg))
        else $error("result appeared without an item in the last stage");

    a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.index == REG_RADIUS |=>
            rad_reg == $past(cfg.data[RAD_W-1:0]))
        else $error("radius write not applied");
`endif

endmodule

`default_nettype wire

FILE: hdl/rsi_mul.sv
// Three-stage pipelined unsigned multiplier built from 24-bit limb products.
`default_nettype none

module rsi_mul (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rsi_pkg::MUL_W-1:0]  a,
    input  logic [rsi_pkg::MUL_W-1:0]  b,
    output logic [rsi_pkg::PROD_W-1:0] p
);
    import rsi_pkg::*;

    logic [2*LIMB_W-1:0] pp_reg [LIMBS][LIMBS];
    logic [ROW_W-1:0]    row_reg [LIMBS];
    logic [ROW_W-1:0]    row_next [LIMBS];
    logic [PROD_W-1:0]   p_reg;
    logic [PROD_W-1:0]   p_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                for (int j = 0; j < LIMBS; j++)
                begin
                    pp_reg[i][j] <= (2*LIMB_W)'(a[i*LIMB_W +: LIMB_W])
                                  * (2*LIMB_W)'(b[j*LIMB_W +: LIMB_W]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < LIMBS; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (j*LIMB_W));
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < LIMBS; i++)
        begin
            p_next = p_next + (PROD_W'(row_reg[i]) << (i*LIMB_W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: hdl/rsi_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband carried alongside.
`default_nettype none

module rsi_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  rsi_pkg::rsi_side_t         in_side,
    input  logic [rsi_pkg::DISC_W-1:0] in_rad,
    output logic                       out_vld,
    output rsi_pkg::rsi_side_t         out_side,
    output logic [rsi_pkg::ROOT_W-1:0] out_root
);
    import rsi_pkg::*;

    logic                vld_reg  [ROOT_W];
    rsi_side_t           side_reg [ROOT_W];
    logic [SQ_REM_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        logic                vld_in;
        rsi_side_t           side_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [ROOT_W-1:0]   root_in;
        logic [ROOT_W-1:0]   root_next;
        logic                ge;

        if (s == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign side_in = in_side;
            assign rem_in  = SQ_REM_W'(in_rad);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign side_in = side_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // Adding bit k to the root grows its square by root*2^(k+1) + 2^(2k).
        assign trial     = (SQ_REM_W'(root_in) << (ROOT_W - s))
                         | (SQ_REM_W'(1) << (2 * (ROOT_W - 1 - s)));
        assign ge        = rem_in >= trial;
        assign rem_next  = ge ? rem_in - trial : rem_in;
        assign root_next = root_in | (ROOT_W'(ge) << (ROOT_W - 1 - s));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_in;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

FILE: tb/ray_sphere_checker.sv
// Scoreboard that predicts every ray result from the observed rays and register writes.
`default_nettype none

module ray_sphere_checker (
    input  logic clk,
    input  logic rst_n,
    rsi_ray_if   ray,
    rsi_res_if   result,
    rsi_cfg_if   cfg,
    output int   errors,
    output int   pending,
    output int   hits
);
    import rsi_pkg::*;

    typedef logic signed [255:0] big_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } crossing_t;

    logic signed [COORD_W-1:0] ctr_x, ctr_y, ctr_z;
    logic [RAD_W-1:0]          radius;
    crossing_t                 crossings[$];

    function automatic logic signed [COORD_W-1:0] clamp_coord(input big_t v);
        if (v > big_t'(COORD_MAX))
            return COORD_MAX;
        else if (v < big_t'(COORD_MIN))
            return COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    function automatic crossing_t nearest_crossing(
        input logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz);
        big_t      o[3], d[3], t[3];
        big_t      a, b, k, disc, s, cand, q, n, mag, off;
        crossing_t r;
        r = '0;
        o[0] = big_t'(ox); o[1] = big_t'(oy); o[2] = big_t'(oz);
        d[0] = big_t'(dx); d[1] = big_t'(dy); d[2] = big_t'(dz);
        t[0] = o[0] - big_t'(ctr_x);
        t[1] = o[1] - big_t'(ctr_y);
        t[2] = o[2] - big_t'(ctr_z);
        a = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (a == 0)
            return r;
        b = d[0] * t[0] + d[1] * t[1] + d[2] * t[2];
        k = t[0] * t[0] + t[1] * t[1] + t[2] * t[2]
            - big_t'({1'b0, radius}) * big_t'({1'b0, radius});
        disc = b * b - a * k;
        if (disc < 0)
            return r;
        s = 0;
        for (int bitpos = 80; bitpos >= 0; bitpos--)
        begin
            cand = s | (big_t'(1) << bitpos);
            if (cand * cand <= disc)
                s = cand;
        end
        q = (b > 0) ? s - b : -b - s;
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            n = d[i] * q;
            mag = (n < 0) ? -n : n;
            off = (2 * mag + a) / (2 * a);
            if (n < 0)
                off = -off;
            case (i)
                0: r.px = clamp_coord(o[i] + off);
                1: r.py = clamp_coord(o[i] + off);
                default: r.pz = clamp_coord(o[i] + off);
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t want;
        crossing_t got;
        if (!rst_n)
        begin
            ctr_x <= '0;
            ctr_y <= '0;
            ctr_z <= '0;
            radius <= RADIUS_RESET;
            crossings.delete();
            errors <= 0;
            pending <= 0;
            hits <= 0;
        end
        else
        begin
            if (ray.valid && ray.ready)
                crossings.push_back(nearest_crossing(ray.origin_x, ray.origin_y,
                    ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z));
            if (result.valid && result.ready)
            begin
                got = {result.hit, result.point_x, result.point_y, result.point_z};
                if (crossings.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result item: hit=%0d (%0d,%0d,%0d)",
                                 got.hit, got.px, got.py, got.pz);
                    errors <= errors + 1;
                end
                else
                begin
                    want = crossings.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected hit=%0d (%0d,%0d,%0d) got hit=%0d (%0d,%0d,%0d)",
                                     want.hit, want.px, want.py, want.pz,
                                     got.hit, got.px, got.py, got.pz);
                        errors <= errors + 1;
                    end
                    if (want.hit)
                        hits <= hits + 1;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CENTER_X: ctr_x <= cfg.data;
                    REG_CENTER_Y: ctr_y <= cfg.data;
                    REG_CENTER_Z: ctr_z <= cfg.data;
                    REG_RADIUS:   radius <= cfg.data[RAD_W-1:0];
                    default: ;
                endcase
            end
            pending <= crossings.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/ray_sphere_intersect_test.sv
// Top of the ray/sphere intersection testbench: clock, reset, stimulus and verdict.
`default_nettype none

module ray_sphere_intersect_test;
    import rsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 130;
    localparam int ONE            = 65536;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    int   errors, pending, hits, rays_sent, idle_cycles;

    rsi_ray_if ray ();
    rsi_res_if result ();
    rsi_cfg_if cfg ();

    ray_sphere_intersect i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray    (ray),
        .result (result),
        .cfg    (cfg)
    );

    ray_sphere_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray     (ray),
        .result  (result),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending),
        .hits    (hits)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        result.ready <= rst_n && (steady || ($urandom_range(99) >= 28));

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((ray.valid && ray.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_ray(input logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz);
        logic rdy;
        while (!steady && $urandom_range(99) < 28)
        begin
            ray.valid <= 1'b0;
            @(posedge clk);
        end
        ray.valid <= 1'b1;
        ray.origin_x <= ox;
        ray.origin_y <= oy;
        ray.origin_z <= oz;
        ray.dir_x <= dx;
        ray.dir_y <= dy;
        ray.dir_z <= dz;
        do
        begin
            @(negedge clk);
            rdy = ray.ready;
            @(posedge clk);
        end
        while (!rdy);
        rays_sent++;
    endtask

    task automatic drain();
        ray.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic rdy;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
        begin
            @(negedge clk);
            rdy = cfg.ready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    task automatic set_sphere(input logic signed [31:0] x, y, z, input logic [31:0] rad);
        drain();
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_CENTER_Z, z);
        write_reg(REG_RADIUS, rad);
        cfg.valid <= 1'b0;
    endtask

    // Most rays start near the sphere and point roughly at its center; the rest are noise.
    task automatic random_rays(input int count, input logic signed [31:0] cx, cy, cz,
                               input int spread);
        logic signed [31:0] o[3], d[3], c[3];
        longint             v;
        c[0] = cx; c[1] = cy; c[2] = cz;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 70)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v = longint'(c[i]) + $signed($urandom_range(2 * spread)) - spread;
                    o[i] = v[31:0];
                    v = longint'(c[i]) - longint'(o[i])
                        + $signed($urandom_range(2 * ONE)) - ONE;
                    d[i] = v[31:0];
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    o[i] = $urandom;
                    d[i] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(
                        8 * ONE)) - 4 * ONE;
                end
            end
            send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        steady = 1'b0;
        rays_sent = 0;
        ray.valid = 1'b0;
        ray.origin_x = '0;
        ray.origin_y = '0;
        ray.origin_z = '0;
        ray.dir_x = '0;
        ray.dir_y = '0;
        ray.dir_z = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unit sphere at the origin straight after reset.
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(0, 0, -3 * ONE, 0, 0, ONE);
        send_ray(0, ONE, -5 * ONE, 0, 0, ONE);
        send_ray(0, 0, 0, ONE, 0, 0);
        send_ray(5 * ONE, 0, 0, 0, 0, ONE);
        send_ray(0, 0, 3 * ONE, 0, 0, -1);
        send_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        send_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_ray(COORD_MAX, 0, 0, COORD_MIN, 0, 0);
        send_ray(0, COORD_MIN, 0, 0, COORD_MAX, 0);
        send_ray(-1, -1, -1, -1, -1, -1);
        send_ray(ONE / 2, ONE / 2, 0, COORD_MAX, COORD_MAX, 1);
        send_ray(-2 * ONE, 0, 0, COORD_MAX, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);

        set_sphere(7 * ONE / 2, -2 * ONE, ONE, 2 * ONE);
        random_rays(150, 7 * ONE / 2, -2 * ONE, ONE, 8 * ONE);

        // Sender holds off until the pipeline is empty, then a stretch with no stalls.
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        steady <= 1'b1;
        set_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 32'h7fffffff);
        random_rays(100, COORD_MAX, COORD_MAX, COORD_MAX, 1 << 30);
        steady <= 1'b0;

        set_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        write_reg(8'd7, 32'hffffffff);
        cfg.valid <= 1'b0;
        send_ray(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, ONE);
        random_rays(100, COORD_MIN, COORD_MIN, COORD_MIN, ONE);

        set_sphere($urandom, $urandom, $urandom, 32'hffffffff);
        random_rays(50, 0, 0, 0, 1 << 30);
        set_sphere(-5 * ONE, 9 * ONE, -ONE, $urandom_range(16 * ONE));
        random_rays(50, -5 * ONE, 9 * ONE, -ONE, 20 * ONE);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d rays over six sphere settings, %0d of them hit.", rays_sent, hits);
        $display("Covered zero direction, tangent, saturation and extreme registers.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/rsi_pkg.sv
hdl/rsi_if.sv
hdl/rsi_mul.sv
hdl/rsi_sqrt.sv
hdl/ray_sphere_intersect.sv
tb/ray_sphere_checker.sv
tb/ray_sphere_intersect_test.sv
